// ===== rtl/rpqc_pkg.sv =====
package rpqc_pkg;

  localparam int RSSI_W = 16;
  localparam int CFG_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int K_W = 13;
  localparam int FRAC_BITS = 20;
  localparam int SLOPE_W = K_W + FRAC_BITS;
  localparam int DIFF_W = SLOPE_W + 1;
  localparam int PROD_W = DIFF_W + RSSI_W + 1;
  localparam int B_W = PROD_W + 1;
  localparam int SUM_W = 64;
  localparam int OUT_SHIFT = 19;

  localparam logic [16:0] DIV10_MUL = 17'd52429;
  localparam int DIV10_SHIFT = 19;
  localparam logic [15:0] OUT_MAX = 16'hffff;
  localparam logic [15:0] OUT_MIN = 16'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POINT_ONE = 2'd0,
    CFG_POINT_TWO = 2'd1,
    CFG_POINT_THREE = 2'd2
  } cfg_index_t;

endpackage

// ===== rtl/rpqc_div_cell.sv =====
module rpqc_div_cell #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 16,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [DEN_W-1:0]  in_rem,
  input  logic [NUM_W-1:0]  in_numq,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [DEN_W-1:0]  out_rem,
  output logic [NUM_W-1:0]  out_numq,
  output logic [DEN_W-1:0]  out_den,
  output logic [SIDE_W-1:0] out_side
);

  logic [DEN_W:0] part;
  logic [DEN_W:0] part_sub;
  logic           ge;
  logic [DEN_W-1:0] rem_next;
  logic [NUM_W-1:0] numq_next;

  assign part = {in_rem, in_numq[NUM_W-1]};
  assign ge = part >= {1'b0, in_den};
  assign part_sub = part - {1'b0, in_den};
  assign rem_next = ge ? part_sub[DEN_W-1:0] : part[DEN_W-1:0];
  assign numq_next = {in_numq[NUM_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rem <= rem_next;
      out_numq <= numq_next;
      out_den <= in_den;
      out_side <= in_side;
    end
  end

endmodule

// ===== rtl/rpqc_div_chain.sv =====
module rpqc_div_chain #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 16,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side,
  output logic              out_valid,
  output logic [NUM_W-1:0]  quo,
  output logic [SIDE_W-1:0] out_side
);

  logic              v_q [NUM_W+1];
  logic [DEN_W-1:0]  rem_q [NUM_W+1];
  logic [NUM_W-1:0]  numq_q [NUM_W+1];
  logic [DEN_W-1:0]  den_q [NUM_W+1];
  logic [SIDE_W-1:0] side_q [NUM_W+1];

  assign v_q[0] = in_valid;
  assign rem_q[0] = '0;
  assign numq_q[0] = num;
  assign den_q[0] = den;
  assign side_q[0] = side;

  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    rpqc_div_cell #(
      .NUM_W(NUM_W),
      .DEN_W(DEN_W),
      .SIDE_W(SIDE_W)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .adv(adv),
      .in_valid(v_q[i]),
      .in_rem(rem_q[i]),
      .in_numq(numq_q[i]),
      .in_den(den_q[i]),
      .in_side(side_q[i]),
      .out_valid(v_q[i+1]),
      .out_rem(rem_q[i+1]),
      .out_numq(numq_q[i+1]),
      .out_den(den_q[i+1]),
      .out_side(side_q[i+1])
    );
  end

  assign out_valid = v_q[NUM_W];
  assign quo = numq_q[NUM_W];
  assign out_side = side_q[NUM_W];

endmodule

// ===== rtl/rx_power_quadratic_calibration_unit.sv =====
// The pipeline holds seven registers and two chains in series of 33 restoring division
// cells each (the two slope chains in parallel, then the quadratic term chain).
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// Reset (synchronous, active high) clears all valid bits and the three calibration
// points to zero.
module rx_power_quadratic_calibration_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] rssi_reading,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] rx_power_word
);

  localparam int RW = rpqc_pkg::RSSI_W;
  localparam int SW = rpqc_pkg::SLOPE_W;
  localparam int DW = rpqc_pkg::DIFF_W;
  localparam int PW = rpqc_pkg::PROD_W;
  localparam int BW = rpqc_pkg::B_W;
  localparam int MW = rpqc_pkg::SUM_W;
  localparam int HI_SIDE_W = 2 * RW + 1;
  localparam int A_SIDE_W = 1 + SW + 2 * RW + 1;

  logic [31:0] cal_one;
  logic [31:0] cal_two;
  logic [31:0] cal_three;
  logic        adv;

  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_one <= '0;
      cal_two <= '0;
      cal_three <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rpqc_pkg::CFG_POINT_ONE:   cal_one <= cfg_data;
        rpqc_pkg::CFG_POINT_TWO:   cal_two <= cfg_data;
        rpqc_pkg::CFG_POINT_THREE: cal_three <= cfg_data;
        default: ;
      endcase
    end
  end

  // Segment selection and power / 10 by reciprocal multiplication.
  logic        low_seg;
  logic [15:0] sel_lo_r, sel_hi_r, sel_lo_p, sel_hi_p;
  logic [32:0] lo_prod, hi_prod;

  assign low_seg = rssi_reading <= cal_two[15:0];
  assign sel_lo_r = low_seg ? cal_two[15:0] : cal_one[15:0];
  assign sel_hi_r = low_seg ? cal_three[15:0] : cal_two[15:0];
  assign sel_lo_p = low_seg ? cal_two[31:16] : cal_one[31:16];
  assign sel_hi_p = low_seg ? cal_three[31:16] : cal_two[31:16];
  assign lo_prod = {17'd0, sel_lo_p} * {16'd0, rpqc_pkg::DIV10_MUL};
  assign hi_prod = {17'd0, sel_hi_p} * {16'd0, rpqc_pkg::DIV10_MUL};

  logic          a_valid;
  logic [RW-1:0] a_rssi, a_lo_r, a_hi_r;
  logic [rpqc_pkg::K_W-1:0] a_lo_k, a_hi_k;
  logic          a_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_rssi <= rssi_reading;
      a_lo_r <= sel_lo_r;
      a_hi_r <= sel_hi_r;
      a_lo_k <= lo_prod[rpqc_pkg::DIV10_SHIFT +: rpqc_pkg::K_W];
      a_hi_k <= hi_prod[rpqc_pkg::DIV10_SHIFT +: rpqc_pkg::K_W];
      a_degen <= (sel_lo_r == '0) || (sel_hi_r == '0) || (sel_lo_r == sel_hi_r);
    end
  end

  logic                 hs_valid, ls_valid;
  logic [SW-1:0]        khi, klo;
  logic [HI_SIDE_W-1:0] hs_side;
  logic [RW-1:0]        ls_lo_r;

  rpqc_div_chain #(.NUM_W(SW), .DEN_W(RW), .SIDE_W(HI_SIDE_W)) u_hi_slope (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .in_valid(a_valid),
    .num({a_hi_k, {rpqc_pkg::FRAC_BITS{1'b0}}}),
    .den(a_hi_r),
    .side({a_rssi, a_hi_r, a_degen}),
    .out_valid(hs_valid),
    .quo(khi),
    .out_side(hs_side)
  );

  rpqc_div_chain #(.NUM_W(SW), .DEN_W(RW), .SIDE_W(RW)) u_lo_slope (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .in_valid(a_valid),
    .num({a_lo_k, {rpqc_pkg::FRAC_BITS{1'b0}}}),
    .den(a_lo_r),
    .side(a_lo_r),
    .out_valid(ls_valid),
    .quo(klo),
    .out_side(ls_lo_r)
  );

  logic [RW-1:0] hs_rssi, hs_hi_r;
  logic          hs_degen;
  logic [DW-1:0] diff;
  logic [RW:0]   dr;

  assign {hs_rssi, hs_hi_r, hs_degen} = hs_side;
  assign diff = {1'b0, khi} - {1'b0, klo};
  assign dr = {1'b0, hs_hi_r} - {1'b0, ls_lo_r};

  logic          b_valid;
  logic [SW-1:0] b_mag_num;
  logic [RW-1:0] b_mag_den;
  logic          b_neg;
  logic [SW-1:0] b_khi;
  logic [RW-1:0] b_hi_r, b_rssi;
  logic          b_degen;
  logic [DW-1:0] diff_abs;
  logic [RW:0]   dr_abs;

  assign diff_abs = diff[DW-1] ? (~diff + 1'b1) : diff;
  assign dr_abs = dr[RW] ? (~dr + 1'b1) : dr;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= hs_valid && ls_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_mag_num <= diff_abs[SW-1:0];
      b_mag_den <= dr_abs[RW-1:0];
      b_neg <= diff[DW-1] ^ dr[RW];
      b_khi <= khi;
      b_hi_r <= hs_hi_r;
      b_rssi <= hs_rssi;
      b_degen <= hs_degen;
    end
  end

  logic                q_valid;
  logic [SW-1:0]       q_mag;
  logic [A_SIDE_W-1:0] q_side;

  rpqc_div_chain #(.NUM_W(SW), .DEN_W(RW), .SIDE_W(A_SIDE_W)) u_coef (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .in_valid(b_valid),
    .num(b_mag_num),
    .den(b_mag_den),
    .side({b_neg, b_khi, b_hi_r, b_rssi, b_degen}),
    .out_valid(q_valid),
    .quo(q_mag),
    .out_side(q_side)
  );

  logic          q_neg, q_degen;
  logic [SW-1:0] q_khi;
  logic [RW-1:0] q_hi_r, q_rssi;
  logic [DW-1:0] q_signed;

  assign {q_neg, q_khi, q_hi_r, q_rssi, q_degen} = q_side;
  assign q_signed = q_neg ? (~{1'b0, q_mag} + 1'b1) : {1'b0, q_mag};

  logic          c_valid;
  logic [DW-1:0] c_a;
  logic [SW-1:0] c_khi;
  logic [RW-1:0] c_hi_r, c_rssi;
  logic          c_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_a <= q_signed;
      c_khi <= q_khi;
      c_hi_r <= q_hi_r;
      c_rssi <= q_rssi;
      c_degen <= q_degen;
    end
  end

  logic [PW-1:0] a_ext, hr_ext, ahr;
  assign a_ext = {{(PW-DW){c_a[DW-1]}}, c_a};
  assign hr_ext = {{(PW-RW){1'b0}}, c_hi_r};
  assign ahr = a_ext * hr_ext;

  logic            d_valid;
  logic [DW-1:0]   d_a;
  logic [PW-1:0]   d_ahr;
  logic [2*RW-1:0] d_rsq;
  logic [SW-1:0]   d_khi;
  logic [RW-1:0]   d_rssi;
  logic            d_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_a <= c_a;
      d_ahr <= ahr;
      d_rsq <= {{RW{1'b0}}, c_rssi} * {{RW{1'b0}}, c_rssi};
      d_khi <= c_khi;
      d_rssi <= c_rssi;
      d_degen <= c_degen;
    end
  end

  logic            e_valid;
  logic [DW-1:0]   e_a;
  logic [BW-1:0]   e_b;
  logic [2*RW-1:0] e_rsq;
  logic [RW-1:0]   e_rssi;
  logic            e_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_a <= d_a;
      e_b <= {{(BW-SW){1'b0}}, d_khi} - {d_ahr[PW-1], d_ahr};
      e_rsq <= d_rsq;
      e_rssi <= d_rssi;
      e_degen <= d_degen;
    end
  end

  logic [MW-1:0] a64, b64;
  assign a64 = {{(MW-DW){e_a[DW-1]}}, e_a};
  assign b64 = {{(MW-BW){e_b[BW-1]}}, e_b};

  logic          f_valid;
  logic [MW-1:0] f_t1, f_t2;
  logic          f_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_t1 <= a64 * {{(MW-2*RW){1'b0}}, e_rsq};
      f_t2 <= b64 * {{(MW-RW){1'b0}}, e_rssi};
      f_degen <= e_degen;
    end
  end

  logic signed [MW-1:0] sum, y1, y2;
  logic [15:0]          result;

  assign sum = $signed(f_t1 + f_t2);
  assign y1 = sum >>> rpqc_pkg::OUT_SHIFT;
  assign y2 = (y1 + 64'sd1) >>> 1;

  always_comb begin
    if (f_degen || y2 <= 64'sd0) begin
      result = rpqc_pkg::OUT_MIN;
    end else if (y2 > 64'sd65535) begin
      result = rpqc_pkg::OUT_MAX;
    end else begin
      result = y2[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rx_power_word <= result;
    end
  end

endmodule

// ===== tb/rx_power_quadratic_calibration_unit_test.sv =====
module rx_power_quadratic_calibration_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 73;
  localparam int CYCLE_LIMIT = 600000;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [15:0] rssi_reading;
  logic out_valid;
  logic out_ready;
  logic [15:0] rx_power_word;

  logic [31:0] cal_points [3];
  logic [15:0] power_queue [$];
  int error_count;
  int cycle_count;
  int hold_off_cycles;
  bit stall_enable;

  rx_power_quadratic_calibration_unit u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rssi_reading(rssi_reading),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .rx_power_word(rx_power_word)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [15:0] predict_power(logic [15:0] rssi);
    longint lo_r;
    longint lo_k;
    longint hi_r;
    longint hi_k;
    longint k_hi;
    longint k_lo;
    longint a;
    longint b;
    longint r;
    longint r1;
    longint r2;
    longint r3;
    logic [63:0] sum;
    r = longint'(rssi);
    r1 = longint'(cal_points[rpqc_pkg::CFG_POINT_ONE][15:0]);
    r2 = longint'(cal_points[rpqc_pkg::CFG_POINT_TWO][15:0]);
    r3 = longint'(cal_points[rpqc_pkg::CFG_POINT_THREE][15:0]);
    if (r <= r2) begin
      lo_r = r2;
      hi_r = r3;
      lo_k = longint'(cal_points[rpqc_pkg::CFG_POINT_TWO][31:16]) / 10;
      hi_k = longint'(cal_points[rpqc_pkg::CFG_POINT_THREE][31:16]) / 10;
    end else begin
      lo_r = r1;
      hi_r = r2;
      lo_k = longint'(cal_points[rpqc_pkg::CFG_POINT_ONE][31:16]) / 10;
      hi_k = longint'(cal_points[rpqc_pkg::CFG_POINT_TWO][31:16]) / 10;
    end
    if (hi_r == 0 || lo_r == 0 || hi_r == lo_r) return 16'd1;
    k_hi = (hi_k <<< 20) / hi_r;
    k_lo = (lo_k <<< 20) / lo_r;
    a = (k_hi - k_lo) / (hi_r - lo_r);
    b = k_hi - a * hi_r;
    sum = a * (r * r) + b * r;
    sum = $signed(sum) >>> 19;
    sum = $signed(sum + 64'd1) >>> 1;
    if (sum[63] || sum == 0) return 16'd1;
    if (sum > 64'd65535) return 16'hffff;
    return sum[15:0];
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  task automatic write_cal_point(rpqc_pkg::cfg_index_t idx, logic [31:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    cal_points[idx] = value;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_reading(logic [15:0] rssi);
    in_valid <= 1'b1;
    rssi_reading <= rssi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    power_queue.push_back(predict_power(rssi));
    @(negedge clk);
  endtask

  task automatic send_burst_reading(logic [15:0] rssi);
    int gap;
    send_reading(rssi);
    if ($urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (power_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  function automatic logic [15:0] random_rssi();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hffff;
      2: return cal_points[rpqc_pkg::CFG_POINT_TWO][15:0] + 16'($urandom_range(0, 2)) - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] random_cal_point();
    logic [15:0] rssi;
    logic [15:0] pwr;
    rssi = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
    pwr = 16'($urandom);
    if ($urandom_range(0, 1) == 1) rssi = 16'($urandom_range(1, 4000));
    return {pwr, rssi};
  endfunction

  task automatic test_reset_defaults();
    send_reading(16'd0);
    send_reading(16'hffff);
    send_reading(16'd1234);
    drain_and_settle();
  endtask

  task automatic test_directed_points();
    write_cal_point(rpqc_pkg::CFG_POINT_ONE, {16'd20000, 16'd3000});
    write_cal_point(rpqc_pkg::CFG_POINT_TWO, {16'd5000, 16'd1000});
    write_cal_point(rpqc_pkg::CFG_POINT_THREE, {16'd500, 16'd100});
    send_reading(16'd0);
    send_reading(16'd1);
    send_reading(16'd100);
    send_reading(16'd999);
    send_reading(16'd1000);
    send_reading(16'd1001);
    send_reading(16'd3000);
    send_reading(16'hffff);
    drain_and_settle();
    write_cal_point(rpqc_pkg::CFG_POINT_TWO, {16'hffff, 16'd0});
    send_reading(16'd0);
    send_reading(16'd5);
    drain_and_settle();
    write_cal_point(rpqc_pkg::CFG_POINT_TWO, {16'hffff, 16'd3000});
    send_reading(16'd3001);
    send_reading(16'd2000);
    drain_and_settle();
    write_cal_point(rpqc_pkg::CFG_POINT_ONE, 32'hffff_ffff);
    write_cal_point(rpqc_pkg::CFG_POINT_TWO, 32'h0000_0001);
    write_cal_point(rpqc_pkg::CFG_POINT_THREE, 32'hffff_fffe);
    send_reading(16'd0);
    send_reading(16'd1);
    send_reading(16'd2);
    send_reading(16'hffff);
    send_reading(16'h8000);
    drain_and_settle();
  endtask

  task automatic test_random_calibrations();
    for (int phase = 0; phase < 24; phase++) begin
      write_cal_point(rpqc_pkg::CFG_POINT_ONE, random_cal_point());
      write_cal_point(rpqc_pkg::CFG_POINT_TWO, random_cal_point());
      write_cal_point(rpqc_pkg::CFG_POINT_THREE, random_cal_point());
      stall_enable = (phase % 4 != 3);
      for (int n = 0; n < 40; n++) send_burst_reading(random_rssi());
      drain_and_settle();
    end
    stall_enable = 1'b1;
  endtask

  task automatic test_back_pressure();
    hold_off_cycles = 300;
    for (int n = 0; n < 150; n++) send_reading(random_rssi());
    drain_and_settle();
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = rpqc_pkg::CFG_POINT_ONE;
    cfg_data = '0;
    in_valid = 1'b0;
    rssi_reading = '0;
    error_count = 0;
    hold_off_cycles = 0;
    stall_enable = 1'b1;
    foreach (cal_points[i]) cal_points[i] = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_defaults();
    test_directed_points();
    test_random_calibrations();
    test_back_pressure();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        hold_off_cycles--;
      end else if (stall_enable) begin
        out_ready <= ($urandom_range(0, 9) > 2);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (power_queue.size() == 0) begin
        report_mismatch("unexpected rx_power_word", rx_power_word, 16'd0);
      end else if (rx_power_word !== power_queue[0]) begin
        report_mismatch("rx_power_word", rx_power_word, power_queue.pop_front());
      end else begin
        void'(power_queue.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
